// ===== hw/rtl/lcg_pkg.sv =====
// Shared types and constants for the LCG random generator
`timescale 1ns / 1ps
package lcg_pkg;

  localparam logic [31:0] LCG_MULT          = 32'd3039177861;
  localparam logic [31:0] SEED_RESET        = 32'd1;
  localparam int          MAX_POISSON_DEF   = 64;
  localparam int          CFG_ADDR_W        = 3;
  localparam logic        CFG_IDX_SEED      = 1'b0;

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_MOD     = 2'd1,
    OP_SCALE   = 2'd2,
    OP_POISSON = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_USE,
    ST_DIV,
    ST_SCALE,
    ST_PCHK,
    ST_PDRAW,
    ST_PGEN,
    ST_PMUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] bound;
    logic [31:0] low;
    logic [31:0] high;
    logic [31:0] limit_fraction;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        error;
  } out_item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

// ===== hw/rtl/lcg_mul.sv =====
// Shared 32x32 multiplier with registered 64-bit product
`timescale 1ns / 1ps
module lcg_mul
  import lcg_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [63:0] prod_r
);

  logic [63:0] prod_nxt;

  assign prod_nxt = {32'd0, req.a} * {32'd0, req.b};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== hw/rtl/lcg_random_generator.sv =====
// LCG random generator: one draw per beat (more for Poisson), sequenced over a shared multiplier.
// Each beat draws a word (DRAW, USE), then goes to DONE for a raw word, via SCALE for
// a scaled uniform, via DIV (one quotient bit a cycle) for modulo, or per Poisson step via PCHK, PDRAW, PGEN, PMUL.
// One item in flight at a time: a new input beat is taken only after the last
// result has left DONE, which waits out any result stall.
// Reset (rst_n low, synchronous) sets seed and generator to 1 and empties
// the result register. No clearing pass.
`timescale 1ns / 1ps
module lcg_random_generator
  import lcg_pkg::*;
#(
  parameter int MAX_POISSON_STEPS = MAX_POISSON_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CNT_W = $clog2(MAX_POISSON_STEPS + 1);

  state_t      state_r, state_nxt;
  in_item_t    item_r, item_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [31:0] gen_r, gen_nxt;
  logic [31:0] span_r, span_nxt;
  logic        rev_r, rev_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [31:0] dsh_r, dsh_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic [31:0] t_r, t_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [31:0] res_r, res_nxt;
  logic        err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  mul_req_t    mul_req;
  logic [63:0] prod_r;
  logic [32:0] span_full;
  logic [31:0] div_r2;
  logic        div_ge;
  logic        cfg_wr;

  lcg_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == CFG_IDX_SEED);
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_SEED) ? seed_r : 32'd0;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign span_full = {1'b0, in_data.high} - {1'b0, in_data.low};

  // restoring divide step: remainder stays below bound, so {rem, bit} fits 32 bits
  assign div_r2 = {rem_r, dsh_r[31]};
  assign div_ge = (div_r2 >= {1'b0, item_r.bound});

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    seed_nxt      = seed_r;
    gen_nxt       = gen_r;
    span_nxt      = span_r;
    rev_nxt       = rev_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    dcnt_nxt      = dcnt_r;
    t_nxt         = t_r;
    pcnt_nxt      = pcnt_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_req.a     = gen_r;
    mul_req.b     = LCG_MULT;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      seed_nxt = cfg_pwdata;
      gen_nxt  = cfg_pwdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          span_nxt  = span_full[31:0];
          rev_nxt   = span_full[32];
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        state_nxt = ST_USE;
      end
      ST_USE: begin
        gen_nxt   = prod_r[31:0];
        res_nxt   = 32'd0;
        err_nxt   = 1'b0;
        mul_req.a = span_r;
        mul_req.b = prod_r[31:0];
        case (op_t'(item_r.op))
          OP_RAW: begin
            res_nxt   = prod_r[31:0];
            state_nxt = ST_DONE;
          end
          OP_MOD: begin
            if (item_r.bound == 31'd0) begin
              err_nxt   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              rem_nxt   = 31'd0;
              dsh_nxt   = prod_r[31:0];
              dcnt_nxt  = 5'd0;
              state_nxt = ST_DIV;
            end
          end
          OP_SCALE: begin
            if (rev_r) begin
              err_nxt   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SCALE;
            end
          end
          OP_POISSON: begin
            t_nxt     = prod_r[31:0];
            pcnt_nxt  = '0;
            state_nxt = ST_PCHK;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? 31'(div_r2 - {1'b0, item_r.bound}) : div_r2[30:0];
        dsh_nxt  = {dsh_r[30:0], 1'b0};
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          res_nxt   = {1'b0, rem_nxt};
          state_nxt = ST_DONE;
        end
      end
      ST_SCALE: begin
        res_nxt   = item_r.low + prod_r[63:32];
        state_nxt = ST_DONE;
      end
      ST_PCHK: begin
        if ((t_r > item_r.limit_fraction) &&
            (pcnt_r < CNT_W'(MAX_POISSON_STEPS))) begin
          pcnt_nxt  = pcnt_r + CNT_W'(1);
          state_nxt = ST_PDRAW;
        end else begin
          res_nxt   = 32'(pcnt_r);
          state_nxt = ST_DONE;
        end
      end
      ST_PDRAW: begin
        state_nxt = ST_PGEN;
      end
      ST_PGEN: begin
        // new uniform straight from the product register into the multiplier
        gen_nxt   = prod_r[31:0];
        mul_req.a = t_r;
        mul_req.b = prod_r[31:0];
        state_nxt = ST_PMUL;
      end
      ST_PMUL: begin
        t_nxt     = prod_r[63:32];
        state_nxt = ST_PCHK;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.value = res_r;
          out_data_nxt.error = err_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= SEED_RESET;
      gen_r       <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    span_r     <= span_nxt;
    rev_r      <= rev_nxt;
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    dcnt_r     <= dcnt_nxt;
    t_r        <= t_nxt;
    pcnt_r     <= pcnt_nxt;
    res_r      <= res_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== test/lcg_draw_checker.sv =====
// Scoreboard for the LCG random generator: predicts each draw and checks the result beats
`timescale 1ns / 1ps
module lcg_draw_checker
  import lcg_pkg::*;
#(
  parameter int MAX_STEPS = MAX_POISSON_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  input  logic [31:0]           cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatch_count,
  output int                    pending_draws,
  output int                    draws_checked,
  output int                    capped_counts
);

  localparam logic [CFG_ADDR_W-1:0] SEED_ADDR = {CFG_IDX_SEED, 2'b00};

  logic [31:0] seed_copy;
  logic [31:0] lcg_state;
  out_item_t   expected_draws[$];
  out_item_t   want;

  // Advances the generator copy as the block does and works out the result.
  function automatic out_item_t predict_draw(input in_item_t req);
    out_item_t   res;
    logic [31:0] word;
    logic [31:0] span;
    logic [31:0] t;
    logic [31:0] count;
    logic [63:0] prod;
    lcg_state = lcg_state * LCG_MULT;
    word = lcg_state;
    res.value = '0;
    res.error = 1'b0;
    case (op_t'(req.op))
      OP_RAW: begin
        res.value = word;
      end
      OP_MOD: begin
        if (req.bound == '0) res.error = 1'b1;
        else res.value = word % {1'b0, req.bound};
      end
      OP_SCALE: begin
        if (req.high < req.low) begin
          res.error = 1'b1;
        end else begin
          span = req.high - req.low;
          prod = {32'd0, span} * {32'd0, word};
          res.value = req.low + prod[63:32];
        end
      end
      default: begin
        // product of uniforms, truncated 0.32 each step
        t = word;
        count = '0;
        while (t > req.limit_fraction && count < MAX_STEPS) begin
          count++;
          lcg_state = lcg_state * LCG_MULT;
          prod = {32'd0, t} * {32'd0, lcg_state};
          t = prod[63:32];
        end
        if (count == MAX_STEPS) capped_counts++;
        res.value = count;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_copy = SEED_RESET;
      lcg_state = SEED_RESET;
      expected_draws.delete();
      mismatch_count = 0;
      draws_checked = 0;
      capped_counts = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_draws.size() == 0) begin
          $display("%0t: result beat with nothing expected: value %h error %b",
                   $time, out_data.value, out_data.error);
          mismatch_count++;
        end else begin
          want = expected_draws.pop_front();
          draws_checked++;
          if (out_data.value !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value, out_data.value);
            mismatch_count++;
          end
          if (out_data.error !== want.error) begin
            $display("%0t: error expected %b actual %b", $time, want.error, out_data.error);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_draws.push_back(predict_draw(in_data));
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == SEED_ADDR) begin
        if (cfg_pwrite) begin
          seed_copy = cfg_pwdata;
          lcg_state = cfg_pwdata;
        end else if (cfg_prdata !== seed_copy) begin
          $display("%0t: seed readback expected %h actual %h", $time, seed_copy, cfg_prdata);
          mismatch_count++;
        end
      end
    end
    pending_draws = expected_draws.size();
  end

endmodule

// ===== test/lcg_random_generator_tb.sv =====
// Top-level testbench for the LCG random generator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module lcg_random_generator_tb;
  import lcg_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] SEED_ADDR  = {CFG_IDX_SEED, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = {~CFG_IDX_SEED, 2'b00};
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 240;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int   mismatch_count;
  int   pending_draws;
  int   draws_checked;
  int   capped_counts;
  int   requests_sent;
  int   seed_writes;
  logic tx_steady;
  logic rx_steady;
  int   rx_beats;

  lcg_random_generator #(
    .MAX_POISSON_STEPS(MAX_POISSON_DEF)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  lcg_draw_checker #(
    .MAX_STEPS(MAX_POISSON_DEF)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .mismatch_count(mismatch_count),
    .pending_draws (pending_draws),
    .draws_checked (draws_checked),
    .capped_counts (capped_counts)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pick_gap(input logic steady);
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic in_item_t make_request(input op_t op, input logic [30:0] bound,
                                            input logic [31:0] low, input logic [31:0] high,
                                            input logic [31:0] limit_fraction);
    in_item_t r;
    r.op             = op;
    r.bound          = bound;
    r.low            = low;
    r.high           = high;
    r.limit_fraction = limit_fraction;
    return r;
  endfunction

  // Unused fields keep random content; the field that matters is shaped per op.
  function automatic in_item_t random_request();
    in_item_t    r;
    int          pick;
    logic [31:0] swap;
    r.op             = 2'($urandom_range(0, 3));
    r.bound          = 31'($urandom);
    r.low            = $urandom;
    r.high           = $urandom;
    r.limit_fraction = $urandom;
    pick             = $urandom_range(0, 9);
    case (op_t'(r.op))
      OP_MOD: begin
        if (pick == 0) r.bound = '0;
        else if (pick < 5) r.bound = 31'($urandom_range(1, 16));
      end
      OP_SCALE: begin
        if (pick == 2) begin
          r.high = r.low;
        end else if (pick > 2 && r.high < r.low) begin
          swap   = r.high;
          r.high = r.low;
          r.low  = swap;
        end
      end
      OP_POISSON: begin
        if (pick == 0) r.limit_fraction = '0;
        else if (pick == 1) r.limit_fraction = '1;
        else if (pick == 2) r.limit_fraction = $urandom >> $urandom_range(20, 31);
        else r.limit_fraction = $urandom >> $urandom_range(0, 12);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_request(input in_item_t req);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic cfg_access(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (write && addr == SEED_ADDR) seed_writes++;
  endtask

  // Drain: every result in, then a pause so the block is back in idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (pending_draws == 0);
    @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Result side: random stall before each beat, with steady stretches.
  initial begin
    out_ready = 1'b0;
    rx_steady = 1'b0;
    rx_beats  = 0;
    @(negedge clk);
    forever begin
      int stall;
      stall = pick_gap(rx_steady);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      rx_beats++;
      if (rx_beats % 90 == 0) rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    tx_steady     = 1'b0;
    requests_sent = 0;
    seed_writes   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset seed: every op and its edge cases
    cfg_access(1'b0, SEED_ADDR, '0);
    send_request(make_request(OP_RAW, '1, '1, '0, '1));
    send_request(make_request(OP_MOD, '0, '1, '1, '1));
    send_request(make_request(OP_MOD, 31'd1, '0, '0, '0));
    send_request(make_request(OP_MOD, '1, '0, '0, '0));
    send_request(make_request(OP_SCALE, '0, 32'd0, '1, '0));
    send_request(make_request(OP_SCALE, '0, 32'd1, 32'd0, '0));
    send_request(make_request(OP_SCALE, '0, '1, '1, '0));
    send_request(make_request(OP_SCALE, '0, 32'd0, 32'd0, '0));
    send_request(make_request(OP_POISSON, '0, '0, '0, '1));
    send_request(make_request(OP_POISSON, '1, '1, '1, '0));
    send_request(make_request(OP_POISSON, '0, '0, '0, 32'h5E2D58D9));
    wait_drained();

    // zero seed sticks at zero
    cfg_access(1'b1, SEED_ADDR, '0);
    cfg_access(1'b0, SEED_ADDR, '0);
    send_request(make_request(OP_RAW, '0, '0, '0, '0));
    send_request(make_request(OP_MOD, 31'd7, '0, '0, '0));
    send_request(make_request(OP_SCALE, '0, '0, '1, '0));
    send_request(make_request(OP_POISSON, '0, '0, '0, '0));
    send_request(make_request(OP_RAW, '1, '1, '1, '1));
    wait_drained();

    // all-ones seed, then a write to an unmapped register that must not land
    cfg_access(1'b1, SEED_ADDR, '1);
    cfg_access(1'b1, SPARE_ADDR, 32'h1234_5678);
    cfg_access(1'b0, SEED_ADDR, '0);
    send_request(make_request(OP_RAW, '0, '0, '0, '0));
    send_request(make_request(OP_POISSON, '0, '0, '0, '0));
    send_request(make_request(OP_MOD, 31'd3, '0, '0, '0));
    send_request(make_request(OP_SCALE, '0, 32'h8000_0000, '1, '0));
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cfg_access(1'b1, SEED_ADDR, (ph == RANDOM_PHASES - 1) ? 32'h8000_0000 : $urandom);
      cfg_access(1'b0, SEED_ADDR, '0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
        if (k % 120 == 119) wait_drained();
        send_request(random_request());
      end
      wait_drained();
    end

    in_valid <= 1'b0;
    wait (pending_draws == 0);
    repeat (300) @(posedge clk);
    $display("Covered %0d requests over all four draw kinds across %0d seed settings",
             requests_sent, seed_writes + 1);
    $display("%0d result beats checked, %0d Poisson counts stopped at the step cap",
             draws_checked, capped_counts);
    if (mismatch_count == 0 && pending_draws == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d results still expected", pending_draws);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lcg_pkg.sv
hw/rtl/lcg_mul.sv
hw/rtl/lcg_random_generator.sv
test/lcg_draw_checker.sv
test/lcg_random_generator_tb.sv
